// File: sv/ctd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the corner triple deduplicator
package ctd_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 1024;
   localparam int DEFAULT_INDEX_BITS  = 24;
   localparam int VERTEX_NUMBER_WIDTH = 10;
   localparam int EPOCH_WIDTH         = 8;
   localparam int QUEUE_DEPTH         = 2;
   localparam int CSR_INDEX_WIDTH     = 8;
   localparam int CSR_DATA_WIDTH      = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_USE_TEX_COORDS = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_USE_NORMALS    = CSR_INDEX_WIDTH'(1);

   typedef struct packed {
      logic [VERTEX_NUMBER_WIDTH-1:0] vertex_number;
      logic                           is_new;
      logic                           overflow;
   } rsp_type;

   localparam int RSP_WIDTH = $bits(rsp_type);

endpackage

// File: sv/corner_triple_deduplicator_unit.sv
`timescale 1ns / 1ps
// top level of the corner triple deduplicator
//
// Corners enter on a queue-style port: a corner transfers on a clock edge with
// push high and full low. Results leave the same way: while empty is low the
// oldest result sits on the rsp_ ports and transfers on an edge with pop high.
// Control registers (use_tex_coords at index 0, use_normals at index 1) are
// written through the csr_ channel, which is always ready; write only while
// no corner is in flight.
// The table unit pops a corner while idle and the output queue has room,
// reads its home slot and checks it, reading the next slot for every live
// slot with another key, then pushes its result into the output queue; the
// table has at least twice as many slots as TABLE_DEPTH, so probe chains stay
// short while it is not crowded. Reset clears the control registers and the
// unique count, then sweeps all 2**(clog2(TABLE_DEPTH)+1) slots, one per cycle;
// full stays high once the input queue has filled during the sweep. A first
// corner that wraps the 8-bit mesh epoch (every 255th new mesh) runs the same
// sweep before its lookup. When the receiver stalls, two results queue up and
// then two more corners, after which full rises.
module corner_triple_deduplicator_unit #(
   parameter int TABLE_DEPTH = ctd_pkg::DEFAULT_TABLE_DEPTH,
   parameter int INDEX_BITS  = ctd_pkg::DEFAULT_INDEX_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [ctd_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [ctd_pkg::CSR_DATA_WIDTH-1:0]      csr_write_data,
   input  logic                                    push,
   output logic                                    full,
   input  logic                                    req_first_corner,
   input  logic [INDEX_BITS-1:0]                   req_position_index,
   input  logic [INDEX_BITS-1:0]                   req_tex_index,
   input  logic                                    req_tex_present,
   input  logic [INDEX_BITS-1:0]                   req_normal_index,
   input  logic                                    req_normal_present,
   output logic                                    empty,
   input  logic                                    pop,
   output logic [ctd_pkg::VERTEX_NUMBER_WIDTH-1:0] rsp_vertex_number,
   output logic                                    rsp_is_new,
   output logic                                    rsp_overflow
);

   import ctd_pkg::*;

   localparam int SLOT_BITS = $clog2(TABLE_DEPTH) + 1;
   localparam int ENTRY_W   = 1 + 3 * INDEX_BITS + SLOT_BITS;

   logic [ENTRY_W-1:0]   front_entry;
   logic [ENTRY_W-1:0]   queued_entry;
   logic                 entry_empty;
   logic                 entry_pop;
   logic                 result_full;
   logic                 result_push;
   rsp_type              result;
   logic [RSP_WIDTH-1:0] rsp_data;
   rsp_type              rsp;

   ctd_front #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .INDEX_BITS  (INDEX_BITS),
      .ENTRY_W     (ENTRY_W)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_first_corner   (req_first_corner),
      .req_position_index (req_position_index),
      .req_tex_index      (req_tex_index),
      .req_tex_present    (req_tex_present),
      .req_normal_index   (req_normal_index),
      .req_normal_present (req_normal_present),
      .entry              (front_entry)
   );

   ctd_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_req_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_entry),
      .full      (full),
      .pop       (entry_pop),
      .pop_data  (queued_entry),
      .empty     (entry_empty)
   );

   ctd_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .INDEX_BITS  (INDEX_BITS),
      .ENTRY_W     (ENTRY_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .entry_valid  (!entry_empty),
      .entry_data   (queued_entry),
      .entry_pop    (entry_pop),
      .result_ready (!result_full),
      .result_push  (result_push),
      .result       (result)
   );

   ctd_queue #(
      .WIDTH (RSP_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result),
      .full      (result_full),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty)
   );

   assign rsp               = rsp_type'(rsp_data);
   assign rsp_vertex_number = rsp.vertex_number;
   assign rsp_is_new        = rsp.is_new;
   assign rsp_overflow      = rsp.overflow;

endmodule

// File: sv/ctd_queue.sv
`timescale 1ns / 1ps
// small register queue between pipeline parts
module ctd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/ctd_front.sv
`timescale 1ns / 1ps
// front part: control registers, key forming and slot hashing
module ctd_front #(
   parameter int TABLE_DEPTH = ctd_pkg::DEFAULT_TABLE_DEPTH,
   parameter int INDEX_BITS  = ctd_pkg::DEFAULT_INDEX_BITS,
   parameter int ENTRY_W     = 1 + 3 * INDEX_BITS + $clog2(TABLE_DEPTH) + 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ctd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [ctd_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   input  logic                                 req_first_corner,
   input  logic [INDEX_BITS-1:0]                req_position_index,
   input  logic [INDEX_BITS-1:0]                req_tex_index,
   input  logic                                 req_tex_present,
   input  logic [INDEX_BITS-1:0]                req_normal_index,
   input  logic                                 req_normal_present,
   output logic [ENTRY_W-1:0]                   entry
);

   import ctd_pkg::*;

   localparam int SLOT_BITS = $clog2(TABLE_DEPTH) + 1;
   localparam int KEY_W     = 3 * INDEX_BITS;

   logic                  use_tex_ff, use_tex_in;
   logic                  use_nrm_ff, use_nrm_in;
   logic [INDEX_BITS-1:0] tex_part;
   logic [INDEX_BITS-1:0] nrm_part;
   logic [KEY_W-1:0]      key;
   logic [SLOT_BITS-1:0]  hash;

   assign csr_ready = 1'b1;

   always_comb begin
      use_tex_in = use_tex_ff;
      use_nrm_in = use_nrm_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_USE_TEX_COORDS: use_tex_in = csr_write_data[0];
            CSR_USE_NORMALS:    use_nrm_in = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_tex_ff <= 1'b0;
         use_nrm_ff <= 1'b0;
      end else begin
         use_tex_ff <= use_tex_in;
         use_nrm_ff <= use_nrm_in;
      end
   end

   assign tex_part = (use_tex_ff && req_tex_present) ? req_tex_index : '0;
   assign nrm_part = (use_nrm_ff && req_normal_present) ? req_normal_index : '0;
   assign key      = {nrm_part, tex_part, req_position_index};

   // xor fold of the key onto the slot address
   always_comb begin
      hash = '0;
      for (int i = 0; i < KEY_W; i++) begin
         hash[i % SLOT_BITS] = hash[i % SLOT_BITS] ^ key[i];
      end
   end

   assign entry = {req_first_corner, key, hash};

endmodule

// File: sv/ctd_back.sv
`timescale 1ns / 1ps
// back part: hashed slot table with linear probing and epoch based emptying
module ctd_back #(
   parameter int TABLE_DEPTH = ctd_pkg::DEFAULT_TABLE_DEPTH,
   parameter int INDEX_BITS  = ctd_pkg::DEFAULT_INDEX_BITS,
   parameter int ENTRY_W     = 1 + 3 * INDEX_BITS + $clog2(TABLE_DEPTH) + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 entry_valid,
   input  logic [ENTRY_W-1:0]   entry_data,
   output logic                 entry_pop,
   input  logic                 result_ready,
   output logic                 result_push,
   output ctd_pkg::rsp_type     result
);

   import ctd_pkg::*;

   localparam int SLOT_BITS = $clog2(TABLE_DEPTH) + 1;
   localparam int SLOTS     = 1 << SLOT_BITS;
   localparam int KEY_W     = 3 * INDEX_BITS;
   localparam int NUM_W     = $clog2(TABLE_DEPTH);
   localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int EPOCH_W   = EPOCH_WIDTH;
   localparam int SLOT_W    = EPOCH_W + KEY_W + NUM_W;
   localparam int VN_W      = VERTEX_NUMBER_WIDTH;

   typedef enum logic [3:0] {
      ST_SWEEP = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_PROBE = 4'b0100,
      ST_CHECK = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [SLOT_BITS-1:0] sweep_addr_ff, sweep_addr_in;
   logic                 resume_ff, resume_in;
   logic [EPOCH_W-1:0]   epoch_ff, epoch_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [SLOT_BITS-1:0] probe_ff, probe_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [SLOT_W-1:0]    rd_data_ff;

   logic [SLOT_W-1:0]    slot_mem [SLOTS];
   logic                 mem_we;
   logic [SLOT_BITS-1:0] mem_waddr;
   logic [SLOT_W-1:0]    mem_wdata;
   logic                 mem_re;
   logic [SLOT_BITS-1:0] mem_raddr;

   logic                 entry_first;
   logic [KEY_W-1:0]     entry_key;
   logic [SLOT_BITS-1:0] entry_hash;
   logic [EPOCH_W-1:0]   rd_epoch;
   logic [KEY_W-1:0]     rd_key;
   logic [NUM_W-1:0]     rd_num;
   logic                 rd_live;
   logic [SLOT_BITS-1:0] probe_next;

   assign entry_first = entry_data[ENTRY_W-1];
   assign entry_key   = entry_data[ENTRY_W-2 -: KEY_W];
   assign entry_hash  = entry_data[SLOT_BITS-1:0];

   assign rd_epoch   = rd_data_ff[SLOT_W-1 -: EPOCH_W];
   assign rd_key     = rd_data_ff[NUM_W +: KEY_W];
   assign rd_num     = rd_data_ff[NUM_W-1:0];
   assign rd_live    = (rd_epoch == epoch_ff);
   assign probe_next = SLOT_BITS'(probe_ff + 1'b1);

   always_comb begin
      state_in      = state_ff;
      sweep_addr_in = sweep_addr_ff;
      resume_in     = resume_ff;
      epoch_in      = epoch_ff;
      count_in      = count_ff;
      probe_in      = probe_ff;
      key_in        = key_ff;
      mem_we        = 1'b0;
      mem_waddr     = probe_ff;
      mem_wdata     = {epoch_ff, key_ff, count_ff[NUM_W-1:0]};
      mem_re        = 1'b0;
      mem_raddr     = probe_ff;
      entry_pop     = 1'b0;
      result_push   = 1'b0;
      result        = '0;

      unique case (state_ff)
         ST_SWEEP: begin
            mem_we        = 1'b1;
            mem_waddr     = sweep_addr_ff;
            mem_wdata     = '0;
            sweep_addr_in = SLOT_BITS'(sweep_addr_ff + 1'b1);
            if (sweep_addr_ff == '1) begin
               sweep_addr_in = '0;
               resume_in     = 1'b0;
               state_in      = resume_ff ? ST_PROBE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (entry_valid && result_ready) begin
               entry_pop = 1'b1;
               key_in    = entry_key;
               probe_in  = entry_hash;
               mem_re    = 1'b1;
               mem_raddr = entry_hash;
               state_in  = ST_CHECK;
               if (entry_first) begin
                  count_in = '0;
                  if (epoch_ff == '1) begin
                     // epoch wraps: stale marks must go before reuse
                     epoch_in  = EPOCH_W'(1);
                     resume_in = 1'b1;
                     mem_re    = 1'b0;
                     state_in  = ST_SWEEP;
                  end else begin
                     epoch_in = EPOCH_W'(epoch_ff + 1'b1);
                  end
               end
            end
         end
         ST_PROBE: begin
            mem_re    = 1'b1;
            mem_raddr = probe_ff;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            if (rd_live && (rd_key == key_ff)) begin
               result_push          = 1'b1;
               result.vertex_number = VN_W'(rd_num);
               state_in             = ST_IDLE;
            end else if (!rd_live) begin
               result_push = 1'b1;
               state_in    = ST_IDLE;
               if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                  result.overflow = 1'b1;
               end else begin
                  mem_we               = 1'b1;
                  count_in             = CNT_W'(count_ff + 1'b1);
                  result.vertex_number = VN_W'(count_ff[NUM_W-1:0]);
                  result.is_new        = 1'b1;
               end
            end else begin
               probe_in  = probe_next;
               mem_re    = 1'b1;
               mem_raddr = probe_next;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_addr_ff <= '0;
         resume_ff     <= 1'b0;
         epoch_ff      <= EPOCH_W'(1);
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         sweep_addr_ff <= sweep_addr_in;
         resume_ff     <= resume_in;
         epoch_ff      <= epoch_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff <= probe_in;
      key_ff   <= key_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= slot_mem[mem_raddr];
      end
   end

endmodule

// File: test/ctd_dedup_checker.sv
`timescale 1ns / 1ps
// transfer monitor, vertex number predictor and result comparator for the deduplicator
module ctd_dedup_checker #(
   parameter int TABLE_DEPTH = ctd_pkg::DEFAULT_TABLE_DEPTH,
   parameter int INDEX_BITS  = ctd_pkg::DEFAULT_INDEX_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   input  logic                                    csr_ready,
   input  logic [ctd_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [ctd_pkg::CSR_DATA_WIDTH-1:0]      csr_write_data,
   input  logic                                    push,
   input  logic                                    full,
   input  logic                                    req_first_corner,
   input  logic [INDEX_BITS-1:0]                   req_position_index,
   input  logic [INDEX_BITS-1:0]                   req_tex_index,
   input  logic                                    req_tex_present,
   input  logic [INDEX_BITS-1:0]                   req_normal_index,
   input  logic                                    req_normal_present,
   input  logic                                    empty,
   input  logic                                    pop,
   input  logic [ctd_pkg::VERTEX_NUMBER_WIDTH-1:0] rsp_vertex_number,
   input  logic                                    rsp_is_new,
   input  logic                                    rsp_overflow,
   output int                                      failure_count,
   output int                                      pending_count
);

   import ctd_pkg::*;

   typedef logic [INDEX_BITS-1:0] index_type;

   index_type known_pos [TABLE_DEPTH];
   index_type known_tex [TABLE_DEPTH];
   index_type known_nrm [TABLE_DEPTH];
   int        known_count = 0;
   logic      tex_enabled = 1'b0;
   logic      nrm_enabled = 1'b0;
   int        errors = 0;
   rsp_type   expected_vertices [$];

   function automatic rsp_type lookup_corner(logic first, index_type pos, index_type tex,
                                             logic tex_on, index_type nrm, logic nrm_on);
      index_type key_tex;
      index_type key_nrm;
      rsp_type   outcome;
      int        hit;
      int        i;
      if (first) begin
         known_count = 0;
      end
      key_tex = (tex_enabled && tex_on) ? tex : '0;
      key_nrm = (nrm_enabled && nrm_on) ? nrm : '0;
      hit = -1;
      i = 0;
      while (hit < 0 && i < known_count) begin
         if (known_pos[i] == pos && known_tex[i] == key_tex && known_nrm[i] == key_nrm) begin
            hit = i;
         end
         i++;
      end
      outcome = '0;
      if (hit >= 0) begin
         outcome.vertex_number = VERTEX_NUMBER_WIDTH'(hit);
      end else if (known_count < TABLE_DEPTH) begin
         known_pos[known_count] = pos;
         known_tex[known_count] = key_tex;
         known_nrm[known_count] = key_nrm;
         outcome.vertex_number = VERTEX_NUMBER_WIDTH'(known_count);
         outcome.is_new = 1'b1;
         known_count++;
      end else begin
         outcome.overflow = 1'b1;
      end
      return outcome;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type predicted;
      if (reset) begin
         known_count = 0;
         tex_enabled = 1'b0;
         nrm_enabled = 1'b0;
         expected_vertices.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_USE_TEX_COORDS) begin
               tex_enabled = csr_write_data[0];
            end else if (csr_index == CSR_USE_NORMALS) begin
               nrm_enabled = csr_write_data[0];
            end
         end
         if (push && !full) begin
            predicted = lookup_corner(req_first_corner, req_position_index,
                                      req_tex_index, req_tex_present,
                                      req_normal_index, req_normal_present);
            expected_vertices = {expected_vertices, predicted};
         end
         if (pop && !empty) begin
            if (expected_vertices.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("unexpected result transfer: vertex_number %0d is_new %0b overflow %0b",
                           rsp_vertex_number, rsp_is_new, rsp_overflow);
               end
            end else begin
               want = expected_vertices.pop_front();
               if (rsp_vertex_number !== want.vertex_number || rsp_is_new !== want.is_new ||
                   rsp_overflow !== want.overflow) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("result mismatch: expected vertex_number %0d is_new %0b overflow %0b,",
                              want.vertex_number, want.is_new, want.overflow,
                              " got vertex_number %0d is_new %0b overflow %0b",
                              rsp_vertex_number, rsp_is_new, rsp_overflow);
                  end
               end
            end
         end
      end
      failure_count <= errors;
      pending_count <= expected_vertices.size();
   end

endmodule

// File: test/tb_corner_triple_deduplicator_unit.sv
`timescale 1ns / 1ps
// testbench top for the corner triple deduplicator: stimulus, receiver stalls and verdict
module tb_corner_triple_deduplicator_unit;
   import ctd_pkg::*;

   localparam int TABLE_DEPTH    = DEFAULT_TABLE_DEPTH;
   localparam int INDEX_BITS     = DEFAULT_INDEX_BITS;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 400;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAST_INDEX = '1;

   typedef logic [INDEX_BITS-1:0] index_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]     csr_index;
   logic [CSR_DATA_WIDTH-1:0]      csr_write_data;
   logic                           push;
   logic                           full;
   logic                           req_first_corner;
   index_type                      req_position_index;
   index_type                      req_tex_index;
   logic                           req_tex_present;
   index_type                      req_normal_index;
   logic                           req_normal_present;
   logic                           empty;
   logic                           pop;
   logic [VERTEX_NUMBER_WIDTH-1:0] rsp_vertex_number;
   logic                           rsp_is_new;
   logic                           rsp_overflow;

   int   failure_count;
   int   pending_results;
   int   stalled_cycles = 0;
   int   corners_sent = 0;
   int   burst_left = 0;
   logic pressure_on = 1'b0;
   logic pressure_done = 1'b0;

   corner_triple_deduplicator_unit #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .INDEX_BITS (INDEX_BITS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .push              (push),
      .full              (full),
      .req_first_corner  (req_first_corner),
      .req_position_index(req_position_index),
      .req_tex_index     (req_tex_index),
      .req_tex_present   (req_tex_present),
      .req_normal_index  (req_normal_index),
      .req_normal_present(req_normal_present),
      .empty             (empty),
      .pop               (pop),
      .rsp_vertex_number (rsp_vertex_number),
      .rsp_is_new        (rsp_is_new),
      .rsp_overflow      (rsp_overflow)
   );

   ctd_dedup_checker #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .INDEX_BITS (INDEX_BITS)
   ) i_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .push              (push),
      .full              (full),
      .req_first_corner  (req_first_corner),
      .req_position_index(req_position_index),
      .req_tex_index     (req_tex_index),
      .req_tex_present   (req_tex_present),
      .req_normal_index  (req_normal_index),
      .req_normal_present(req_normal_present),
      .empty             (empty),
      .pop               (pop),
      .rsp_vertex_number (rsp_vertex_number),
      .rsp_is_new        (rsp_is_new),
      .rsp_overflow      (rsp_overflow),
      .failure_count     (failure_count),
      .pending_count     (pending_results)
   );

   always #5ns clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 88) begin
         return $urandom_range(1, 3);
      end else if (roll < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(25, 80);
   endfunction

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_corner_triple_deduplicator_unit failed");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   // result side, with one long hold-off as soon as pressure is requested
   initial begin
      int span;
      pop = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (pressure_on && !pressure_done) begin
            pressure_done = 1'b1;
            pop = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         span = idle_cycles();
         for (int c = 0; c < span && !(pressure_on && !pressure_done); c++) begin
            pop = 1'b0;
            @(negedge clock);
         end
         span = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
         for (int c = 0; c < span && !(pressure_on && !pressure_done); c++) begin
            pop = 1'b1;
            @(negedge clock);
         end
      end
   end

   task automatic send_corner(logic first, index_type pos, index_type tex, logic tex_on,
                              index_type nrm, logic nrm_on);
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 39) == 0) begin
            burst_left = $urandom_range(10, 40);
         end
         gap = idle_cycles();
      end
      @(negedge clock);
      repeat (gap) begin
         push = 1'b0;
         @(negedge clock);
      end
      req_first_corner = first;
      req_position_index = pos;
      req_tex_index = tex;
      req_tex_present = tex_on;
      req_normal_index = nrm;
      req_normal_present = nrm_on;
      push = 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      corners_sent++;
   endtask

   task automatic send_noise_corner();
      send_corner(1'($urandom_range(0, 1)), index_type'($urandom()), index_type'($urandom()),
                  1'($urandom_range(0, 1)), index_type'($urandom()), 1'($urandom_range(0, 1)));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      push = 1'b0;
      while (pending_results != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] index, logic [CSR_DATA_WIDTH-1:0] word);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_write_data = word;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic end_csr();
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic configure(logic tex_on, logic nrm_on);
      logic [CSR_DATA_WIDTH-1:0] word;
      wait_drained();
      word = $urandom();
      word[0] = tex_on;
      write_csr(CSR_USE_TEX_COORDS, word);
      word = $urandom();
      word[0] = nrm_on;
      write_csr(CSR_USE_NORMALS, word);
      if ($urandom_range(0, 2) == 0) begin
         write_csr(CSR_INDEX_WIDTH'($urandom_range(CSR_USE_NORMALS + 1, CSR_LAST_INDEX)),
                   $urandom());
      end
      end_csr();
   endtask

   // one mesh drawn from small index pools so that corners repeat
   task automatic run_mesh(int corners);
      index_type pos_base;
      index_type tex_base;
      index_type nrm_base;
      int        spread;
      int        tex_mode;
      int        nrm_mode;
      logic      tex_on;
      logic      nrm_on;
      pos_base = $urandom();
      tex_base = $urandom();
      nrm_base = $urandom();
      spread = $urandom_range(1, 12);
      tex_mode = $urandom_range(0, 2);
      nrm_mode = $urandom_range(0, 2);
      for (int k = 0; k < corners; k++) begin
         if ($urandom_range(0, 19) == 0) begin
            send_noise_corner();
         end else begin
            tex_on = (tex_mode == 2) ? 1'($urandom_range(0, 1)) : 1'(tex_mode);
            nrm_on = (nrm_mode == 2) ? 1'($urandom_range(0, 1)) : 1'(nrm_mode);
            send_corner(k == 0, pos_base + index_type'($urandom_range(0, spread)),
                        tex_base + index_type'($urandom_range(0, spread)), tex_on,
                        nrm_base + index_type'($urandom_range(0, spread)), nrm_on);
         end
      end
   endtask

   initial begin
      logic setting [4][2];
      int   target;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      push = 1'b0;
      req_first_corner = 1'b0;
      req_position_index = '0;
      req_tex_index = '0;
      req_tex_present = 1'b0;
      req_normal_index = '0;
      req_normal_present = 1'b0;
      setting = '{'{1'b0, 1'b0}, '{1'b1, 1'b1}, '{1'b1, 1'b0}, '{1'b0, 1'b1}};
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // both parts disabled out of reset
      send_corner(1'b1, '0, '1, 1'b1, '1, 1'b1);
      send_corner(1'b0, '0, 24'd5, 1'b1, 24'd9, 1'b0);
      send_corner(1'b0, '1, '0, 1'b0, '0, 1'b0);
      send_corner(1'b0, 24'h555555, 24'h555555, 1'b1, 24'hAAAAAA, 1'b1);
      send_corner(1'b0, '1, '1, 1'b1, '1, 1'b1);

      // texture only, upper data bits ignored, write past the register list
      wait_drained();
      write_csr(CSR_USE_TEX_COORDS, '1);
      write_csr(CSR_USE_NORMALS, 32'hFFFF_FFFE);
      write_csr(CSR_LAST_INDEX, '1);
      end_csr();
      send_corner(1'b1, 24'd7, 24'd3, 1'b1, 24'd4, 1'b1);
      send_corner(1'b0, 24'd7, 24'd3, 1'b0, 24'd4, 1'b1);
      send_corner(1'b0, 24'd7, '0, 1'b1, 24'd8, 1'b0);
      send_corner(1'b0, 24'd7, 24'd3, 1'b1, '0, 1'b0);
      send_corner(1'b0, '1, '1, 1'b1, '0, 1'b0);

      configure(1'b1, 1'b1);
      send_corner(1'b1, '0, '0, 1'b0, '0, 1'b0);
      send_corner(1'b0, '0, '0, 1'b1, '0, 1'b1);
      send_corner(1'b0, '0, '1, 1'b1, '1, 1'b1);
      send_corner(1'b0, '0, '1, 1'b1, '1, 1'b0);
      send_corner(1'b0, '0, '1, 1'b0, '1, 1'b1);
      send_corner(1'b0, '0, '1, 1'b1, '1, 1'b1);
      send_corner(1'b1, '0, '1, 1'b1, '1, 1'b1);
      send_corner(1'b0, 24'hAAAAAA, 24'h555555, 1'b1, 24'hAAAAAA, 1'b1);

      configure(1'b0, 1'b1);
      send_corner(1'b1, '1, 24'h123456, 1'b1, 24'h654321, 1'b1);
      send_corner(1'b0, '1, '0, 1'b0, 24'h654321, 1'b1);

      // random meshes under every setting, then some random settings
      for (int seg = 0; seg < 6; seg++) begin
         if (seg < 4) begin
            configure(setting[seg][0], setting[seg][1]);
         end else begin
            configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
         if (seg == 1) begin
            pressure_on = 1'b1;
         end
         target = corners_sent + 50;
         while (corners_sent < target) begin
            run_mesh(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40));
         end
      end

      // many single-corner meshes so the mesh epoch wraps
      configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      for (int k = 0; k < 260; k++) begin
         send_corner(1'b1, index_type'($urandom()), index_type'($urandom()),
                     1'($urandom_range(0, 1)), index_type'($urandom()),
                     1'($urandom_range(0, 1)));
      end

      @(negedge clock);
      push = 1'b0;
      while (pending_results != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failure_count == 0) begin
         $display("tb_corner_triple_deduplicator_unit passed");
      end else begin
         $display("tb_corner_triple_deduplicator_unit failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/ctd_pkg.sv
sv/ctd_queue.sv
sv/ctd_front.sv
sv/ctd_back.sv
sv/corner_triple_deduplicator_unit.sv
test/ctd_dedup_checker.sv
test/tb_corner_triple_deduplicator_unit.sv
